>>> rtl/core/mtt_pkg.sv
// Package for the timer table block: field widths, codes, command and slot types.
// Used by every module under rtl/core but mtt_ram; depends on nothing else.
package mtt_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam int ACTION_W   = 2;
    localparam int OWNER_W    = 8;
    localparam int ID_W       = 16;
    localparam int INTERVAL_W = 16;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 1 + OWNER_W + ID_W + INTERVAL_W + INTERVAL_W;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 32;
    localparam int M_PAD_W    = M_TDATA_W - (STATUS_W + OWNER_W + ID_W);

    localparam logic [ACTION_W-1:0] ACTION_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACTION_ADD    = 2'd1;
    localparam logic [ACTION_W-1:0] ACTION_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_NOTIFY = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_ADD,
        OP_REMOVE
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        op_t                   op;
        logic [OWNER_W-1:0]    owner;
        logic [ID_W-1:0]       id;
        logic [INTERVAL_W-1:0] interval;
        logic                  once;
    } cmd_t;

    typedef struct packed {
        logic                  once;
        logic [OWNER_W-1:0]    owner;
        logic [ID_W-1:0]       id;
        logic [INTERVAL_W-1:0] interval;
        logic [INTERVAL_W-1:0] remaining;
    } slot_word_t;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [OWNER_W-1:0]  owner;
        logic [ID_W-1:0]     id;
        logic                last;
    } result_t;

endpackage

>>> rtl/core/mtt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mtt_front.sv
// Front end of the timer table: takes input transfers, decodes the action
// and forwards tick, add and remove commands to the queue. Uses mtt_pkg.
module mtt_front
    import mtt_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [ACTION_W-1:0]  s_axis_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic keep;
    op_t  op;

    always_comb begin
        keep = 1'b1;
        op   = OP_TICK;
        unique case (s_axis_tuser)
            ACTION_TICK:   op = OP_TICK;
            ACTION_ADD:    op = OP_ADD;
            ACTION_REMOVE: op = OP_REMOVE;
            default:       keep = 1'b0;
        endcase
    end

    assign s_axis_tready  = !q_full;
    assign q_push         = s_axis_tvalid && !q_full && keep;
    assign q_cmd.op       = op;
    assign q_cmd.owner    = s_axis_tdata[7:0];
    assign q_cmd.id       = s_axis_tdata[23:8];
    assign q_cmd.interval = s_axis_tdata[39:24];
    assign q_cmd.once     = s_axis_tdata[40];

endmodule

>>> rtl/core/mtt_queue.sv
// Short command queue between the front end and the slot scanner.
// Uses mtt_pkg for the command type and depth.
module mtt_queue
    import mtt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/mtt_back.sv
// Back end of the timer table: scans the slot RAM one slot per cycle (barring output
// stalls) for each command and drives the result register. Uses mtt_pkg and mtt_ram.
module mtt_back
    import mtt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  cmd_t    q_cmd,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]  ev_idx_reg, ev_idx_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic              dup_reg, dup_next;
    logic              free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              found_reg, found_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [OWNER_W-1:0] pend_owner_reg, pend_owner_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic              out_vld_reg, out_vld_next;
    result_t           out_res_reg, out_res_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    slot_word_t        ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;
    slot_word_t        slot;

    logic              ev_live, key_hit, fire, out_free, ev_stall, adv, scan_end;
    logic              cnt_more, done_go;
    logic [STATUS_W-1:0] add_status;

    mtt_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign slot     = ram_rdata;
    assign ev_live  = ev_vld_reg && valid_reg[ev_idx_reg];
    assign key_hit  = ev_live && (slot.owner == cmd_reg.owner) && (slot.id == cmd_reg.id);
    assign fire     = ev_live && (cmd_reg.op == OP_TICK) && (slot.remaining <= 16'd1);
    assign out_free = !out_vld_reg || out_ready;
    assign ev_stall = fire && pend_vld_reg && !out_free;
    assign adv      = !ev_vld_reg || !ev_stall;
    assign cnt_more = (cnt_reg < CNT_W'(SLOTS));
    assign scan_end = !cnt_more && !ev_vld_reg;
    assign done_go  = out_free || ((cmd_reg.op == OP_TICK) && !pend_vld_reg);

    always_comb begin
        if (cmd_reg.interval == '0) begin
            add_status = ST_ZERO;
        end else if (dup_reg) begin
            add_status = ST_DUP;
        end else if (!free_vld_reg) begin
            add_status = ST_FULL;
        end else begin
            add_status = ST_OK;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (scan_end) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (done_go) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        ev_vld_next     = ev_vld_reg;
        ev_idx_next     = ev_idx_reg;
        valid_next      = valid_reg;
        dup_next        = dup_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        found_next      = found_reg;
        pend_vld_next   = pend_vld_reg;
        pend_owner_next = pend_owner_reg;
        pend_id_next    = pend_id_reg;
        out_vld_next    = out_vld_reg && !out_ready;
        out_res_next    = out_res_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = ev_idx_reg;
        ram_wdata       = slot;
        ram_raddr       = ev_idx_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    cmd_next      = q_cmd;
                    cnt_next      = '0;
                    ev_vld_next   = 1'b0;
                    dup_next      = 1'b0;
                    free_vld_next = 1'b0;
                    found_next    = 1'b0;
                    pend_vld_next = 1'b0;
                end
            end
            BK_SCAN: begin
                if (adv) begin
                    ram_raddr   = cnt_reg[IDX_W-1:0];
                    ev_vld_next = cnt_more;
                    ev_idx_next = cnt_reg[IDX_W-1:0];
                    if (cnt_more) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                if (ev_vld_reg && adv) begin
                    case (cmd_reg.op)
                        OP_TICK: begin
                            if (ev_live && !fire) begin
                                ram_we              = 1'b1;
                                ram_wdata.remaining = slot.remaining - 16'd1;
                            end else if (fire) begin
                                if (pend_vld_reg) begin
                                    out_vld_next        = 1'b1;
                                    out_res_next.kind   = KIND_NOTIFY;
                                    out_res_next.status = ST_OK;
                                    out_res_next.owner  = pend_owner_reg;
                                    out_res_next.id     = pend_id_reg;
                                    out_res_next.last   = 1'b0;
                                end
                                pend_vld_next   = 1'b1;
                                pend_owner_next = slot.owner;
                                pend_id_next    = slot.id;
                                if (slot.once) begin
                                    valid_next[ev_idx_reg] = 1'b0;
                                end else begin
                                    ram_we              = 1'b1;
                                    ram_wdata.remaining = slot.interval;
                                end
                            end
                        end
                        OP_ADD: begin
                            if (key_hit) begin
                                dup_next = 1'b1;
                            end
                            if (!valid_reg[ev_idx_reg] && !free_vld_reg) begin
                                free_vld_next = 1'b1;
                                free_idx_next = ev_idx_reg;
                            end
                        end
                        OP_REMOVE: begin
                            if (key_hit && !found_reg) begin
                                found_next             = 1'b1;
                                valid_next[ev_idx_reg] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_DONE: begin
                if (done_go) begin
                    case (cmd_reg.op)
                        OP_TICK: begin
                            if (pend_vld_reg) begin
                                out_vld_next        = 1'b1;
                                out_res_next.kind   = KIND_NOTIFY;
                                out_res_next.status = ST_OK;
                                out_res_next.owner  = pend_owner_reg;
                                out_res_next.id     = pend_id_reg;
                                out_res_next.last   = 1'b1;
                            end
                        end
                        OP_ADD: begin
                            out_vld_next        = 1'b1;
                            out_res_next.kind   = KIND_STATUS;
                            out_res_next.status = add_status;
                            out_res_next.owner  = '0;
                            out_res_next.id     = '0;
                            out_res_next.last   = 1'b1;
                            if (add_status == ST_OK) begin
                                ram_we                   = 1'b1;
                                ram_waddr                = free_idx_reg;
                                ram_wdata.once           = cmd_reg.once;
                                ram_wdata.owner          = cmd_reg.owner;
                                ram_wdata.id             = cmd_reg.id;
                                ram_wdata.interval       = cmd_reg.interval;
                                ram_wdata.remaining      = cmd_reg.interval;
                                valid_next[free_idx_reg] = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            out_vld_next        = 1'b1;
                            out_res_next.kind   = KIND_STATUS;
                            out_res_next.status = found_reg ? ST_OK : ST_NOT_FOUND;
                            out_res_next.owner  = '0;
                            out_res_next.id     = '0;
                            out_res_next.last   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg    <= BK_IDLE;
            ev_vld_reg   <= 1'b0;
            valid_reg    <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ev_vld_reg   <= ev_vld_next;
            valid_reg    <= valid_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk) begin
        cmd_reg        <= cmd_next;
        cnt_reg        <= cnt_next;
        ev_idx_reg     <= ev_idx_next;
        dup_reg        <= dup_next;
        free_vld_reg   <= free_vld_next;
        free_idx_reg   <= free_idx_next;
        found_reg      <= found_next;
        pend_owner_reg <= pend_owner_next;
        pend_id_reg    <= pend_id_next;
        out_res_reg    <= out_res_next;
    end

    assign out_valid = out_vld_reg;
    assign out_res   = out_res_reg;

endmodule

>>> rtl/core/multi_timer_table_unit.sv
// Top level of the timer table: front end, command queue and slot scanner.
// Depends on mtt_pkg, mtt_front, mtt_queue, mtt_back and mtt_ram.
//
// The s_axis channel carries commands: tuser selects tick, add or remove, and
// tdata holds owner, timer id, interval and the one-shot flag. The m_axis
// channel carries results: tuser tells a status reply from an expiry
// notification, tdata holds status, owner and id, and tlast marks the final
// result of a command. A command with the unused action code is taken and
// dropped. Add and remove give one reply; a tick gives one notification per
// expired timer, in slot order, and nothing when no timer expires.
// The scanner handles one command at a time and reads one slot of the slot RAM
// per cycle while the receiver keeps up. A two-entry queue lets the input
// channel take up to two further commands meanwhile. While the receiver
// stalls, the scan holds at the next expiring slot and the queue fills.
// Reset frees all slots and empties the queue; the slot RAM needs no clearing.
module multi_timer_table_unit
    import mtt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // owner [7:0], timer_id [23:8], interval [39:24], once [40], zero [47:41]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // action [1:0]
    input  logic [ACTION_W-1:0]  s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status [2:0], fired_owner [10:3], fired_id [26:11], zero [31:27]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // kind [0]
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast
);

    logic    q_push, q_full, q_pop, q_valid;
    cmd_t    push_cmd, head_cmd;
    result_t res;

    mtt_front u_front (
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    mtt_queue u_queue (
        .clk     (aclk),
        .rst_n   (aresetn),
        .push    (q_push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head    (head_cmd)
    );

    mtt_back #(
        .SLOTS(SLOTS)
    ) u_back (
        .clk      (aclk),
        .rst_n    (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_res  (res)
    );

    assign m_axis_tdata = {{M_PAD_W{1'b0}}, res.id, res.owner, res.status};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_reply_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_STATUS) |-> m_axis_tlast)
        else $error("status reply without tlast");

    a_notify_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_NOTIFY) |-> (m_axis_tdata[2:0] == ST_OK))
        else $error("notification with a nonzero status");

    a_reply_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_STATUS) |-> (m_axis_tdata[26:3] == '0))
        else $error("status reply carries an owner or id");
`endif

endmodule
